FILE: design/btce_pkg.sv
package btce_pkg;

    // Default level limits, used as parameter defaults on the top level.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 512;

    // Field widths of the stream payloads.
    localparam int ACT_W       = 2;
    localparam int X_W         = 10;
    localparam int Y_W         = 9;
    localparam int R_W         = 10;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;

    // Configuration port.
    localparam int LW_W        = 11;
    localparam int LH_W        = 10;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HEIGHT = 1'b1;
    localparam logic [LW_W-1:0] LW_RESET = 11'd1024;
    localparam logic [LH_W-1:0] LH_RESET = 10'd512;

    // Signed coordinate width: covers centre plus or minus radius.
    localparam int CRD_W  = 13;
    // Shared multiplier operand and product widths.
    localparam int OP_W   = 10;
    localparam int PROD_W = 2 * OP_W;

    // Leftmost pixel of a byte sits in its most significant bit.
    localparam logic [7:0] PIX_MSB = 8'h80;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CUT   = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIX_ADDR,
        ST_PIX_READ,
        ST_PIX_USE,
        ST_CUT_SETUP,
        ST_CUT_RSQ,
        ST_ROW_DY,
        ST_ROW_BASE,
        ST_ROW_ADDR,
        ST_BYTE_READ,
        ST_PIX_MUL,
        ST_PIX_CMP,
        ST_BYTE_WRITE,
        ST_RESULT
    } state_t;

    // Operand pair handed to the shared multiplier.
    typedef struct packed {
        logic [OP_W-1:0] a;
        logic [OP_W-1:0] b;
    } mul_req_t;

endpackage

FILE: design/btce_mul.sv
module btce_mul
    import btce_pkg::*;
(
    input  logic              aclk,
    input  mul_req_t          req,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    // One registered product per cycle; the sequencer reads it in the next cycle.
    always_ff @(posedge aclk) begin
        prod_reg <= req.a * req.b;
    end

    assign prod = prod_reg;

endmodule

FILE: design/bitmap_terrain_circle_eraser_unit.sv
// Loads and queries read the addressed byte, then write it back or pick its bit; unknown actions
// go straight to the result. A cut walks its clipped box row by row and byte by byte, paced by
// the single shared multiplier that squares one distance per pixel; an empty box is skipped.
// Throughput is one transaction at a time; the next one is taken as soon as the result
// is registered, even if it has not yet been taken.
// Reset (synchronous, active low) clears the sequencer and output valid and sets the
// level size to 1024 x 512; the terrain memory is not cleared.
module bitmap_terrain_circle_eraser_unit
    import btce_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pos_x[9:0], pos_y[18:10], radius[28:19], solid[29]
    input  logic [ACT_W-1:0]     s_tuser,   // action[1:0]
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // ground[0]
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int ROW_BYTES = MAX_WIDTH / 8;
    localparam int DEPTH     = ROW_BYTES * MAX_HEIGHT;
    localparam int AW        = $clog2(DEPTH);

    // Byte address from a row base product and a pixel column.
    function automatic logic [AW-1:0] byte_addr(input logic [PROD_W-1:0] base,
                                                input logic [CRD_W-1:0]  col);
        logic [PROD_W+1:0] sum;
        sum = (PROD_W+2)'(base) + (PROD_W+2)'(col[CRD_W-1:3]);
        return sum[AW-1:0];
    endfunction

    // Configuration registers.
    logic [LW_W-1:0] lw_reg;
    logic [LH_W-1:0] lh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg <= LW_RESET;
            lh_reg <= LH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_LEVEL_WIDTH:  lw_reg <= cfg_wdata[LW_W-1:0];
                REG_LEVEL_HEIGHT: lh_reg <= cfg_wdata[LH_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective level size: saturated at the maximum, rounded down to whole bytes.
    logic [CRD_W-1:0] w_min, h_min, eff_w, eff_h;

    always_comb begin
        w_min = (CRD_W'(lw_reg) > CRD_W'(MAX_WIDTH)) ? CRD_W'(MAX_WIDTH) : CRD_W'(lw_reg);
        h_min = (CRD_W'(lh_reg) > CRD_W'(MAX_HEIGHT)) ? CRD_W'(MAX_HEIGHT) : CRD_W'(lh_reg);
        eff_w = {w_min[CRD_W-1:3], 3'b000};
        eff_h = {h_min[CRD_W-1:3], 3'b000};
    end

    // Sequencer and datapath registers.
    state_t            state_reg, state_next;
    action_t           act_reg, act_next;
    logic [X_W-1:0]    cx_reg, cx_next;
    logic [Y_W-1:0]    cy_reg, cy_next;
    logic [R_W-1:0]    r_reg, r_next;
    logic              solid_reg, solid_next;
    logic [CRD_W-1:0]  x0_reg, x0_next, x1_reg, x1_next;
    logic [CRD_W-1:0]  y1_reg, y1_next;
    logic [CRD_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic [PROD_W-1:0] rsq_reg, rsq_next, dysq_reg, dysq_next, base_reg, base_next;
    logic [7:0]        mask_reg, mask_next;
    logic [AW-1:0]     byte_addr_reg, byte_addr_next;
    logic              ground_reg, ground_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_ground_reg, m_ground_next;

    // Terrain memory.
    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_addr;
    logic [7:0]        mem_wdata;

    // Shared multiplier.
    mul_req_t          mul_req;
    logic [PROD_W-1:0] mul_prod;

    btce_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    // Signed helpers for the cut geometry.
    logic signed [CRD_W-1:0] cx_s, cy_s, r_s, sx0, sx1, sy0, sy1, x0c, x1c, y0c, y1c;
    logic signed [CRD_W-1:0] dx_s, dy_s, dx_abs, dy_abs;
    logic [CRD_W-1:0]        col_inc;
    logic [PROD_W:0]         dist_sum;
    logic [7:0]              pix_bit;

    always_comb begin
        cx_s   = CRD_W'(cx_reg);
        cy_s   = CRD_W'(cy_reg);
        r_s    = CRD_W'(r_reg);
        sx0    = cx_s - r_s;
        sx1    = cx_s + r_s;
        sy0    = cy_s - r_s;
        sy1    = cy_s + r_s;
        x0c    = (sx0 < 0) ? '0 : sx0;
        y0c    = (sy0 < 0) ? '0 : sy0;
        x1c    = (sx1 > $signed(eff_w)) ? $signed(eff_w) : sx1;
        y1c    = (sy1 > $signed(eff_h)) ? $signed(eff_h) : sy1;
        dx_s   = $signed(col_reg) - cx_s;
        dy_s   = $signed(row_reg) - cy_s;
        dx_abs = dx_s[CRD_W-1] ? -dx_s : dx_s;
        dy_abs = dy_s[CRD_W-1] ? -dy_s : dy_s;
        col_inc  = col_reg + CRD_W'(1);
        dist_sum = {1'b0, mul_prod} + {1'b0, dysq_reg};
        pix_bit  = PIX_MSB >> col_reg[2:0];
    end

    // State register and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        r_reg         <= r_next;
        solid_reg     <= solid_next;
        x0_reg        <= x0_next;
        x1_reg        <= x1_next;
        y1_reg        <= y1_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        rsq_reg       <= rsq_next;
        dysq_reg      <= dysq_next;
        base_reg      <= base_next;
        mask_reg      <= mask_next;
        byte_addr_reg <= byte_addr_next;
        ground_reg    <= ground_next;
        m_ground_reg  <= m_ground_next;
    end

    // Next state and outputs of the sequencer.
    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        r_next         = r_reg;
        solid_next     = solid_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rsq_next       = rsq_reg;
        dysq_next      = dysq_reg;
        base_next      = base_reg;
        mask_next      = mask_reg;
        byte_addr_next = byte_addr_reg;
        ground_next    = ground_reg;
        m_ground_next  = m_ground_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = byte_addr_reg;
        mem_wdata      = rd_data_reg;
        mul_req.a      = OP_W'(r_reg);
        mul_req.b      = OP_W'(r_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next    = action_t'(s_tuser);
                    cx_next     = s_tdata[X_W-1:0];
                    cy_next     = s_tdata[X_W +: Y_W];
                    r_next      = s_tdata[X_W+Y_W +: R_W];
                    solid_next  = s_tdata[X_W+Y_W+R_W];
                    ground_next = 1'b0;
                    case (action_t'(s_tuser))
                        ACT_LOAD, ACT_QUERY: state_next = ST_PIX_ADDR;
                        ACT_CUT:             state_next = ST_CUT_SETUP;
                        default:             state_next = ST_RESULT;
                    endcase
                end
            end

            // Single pixel: bounds check and row base product.
            ST_PIX_ADDR: begin
                mul_req.a = OP_W'(cy_reg);
                mul_req.b = OP_W'(ROW_BYTES);
                if (CRD_W'(cx_reg) < eff_w && CRD_W'(cy_reg) < eff_h) begin
                    state_next = ST_PIX_READ;
                end else begin
                    state_next = ST_RESULT;
                end
            end

            ST_PIX_READ: begin
                mem_re         = 1'b1;
                mem_addr       = byte_addr(mul_prod, CRD_W'(cx_reg));
                byte_addr_next = mem_addr;
                state_next     = ST_PIX_USE;
            end

            // Read-modify-write for a load, bit pick for a query.
            ST_PIX_USE: begin
                if (act_reg == ACT_LOAD) begin
                    mem_we    = 1'b1;
                    mem_wdata = solid_reg ? (rd_data_reg | (PIX_MSB >> cx_reg[2:0]))
                                          : (rd_data_reg & ~(PIX_MSB >> cx_reg[2:0]));
                end else begin
                    ground_next = |(rd_data_reg & (PIX_MSB >> cx_reg[2:0]));
                end
                state_next = ST_RESULT;
            end

            // Clip the bounding box and square the radius.
            ST_CUT_SETUP: begin
                x0_next = x0c;
                x1_next = x1c;
                y1_next = y1c;
                row_next = y0c;
                if (x0c >= x1c || y0c >= y1c) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_CUT_RSQ;
                end
            end

            ST_CUT_RSQ: begin
                rsq_next   = mul_prod;
                state_next = ST_ROW_DY;
            end

            ST_ROW_DY: begin
                mul_req.a  = OP_W'(dy_abs);
                mul_req.b  = OP_W'(dy_abs);
                state_next = ST_ROW_BASE;
            end

            ST_ROW_BASE: begin
                dysq_next  = mul_prod;
                mul_req.a  = OP_W'(row_reg);
                mul_req.b  = OP_W'(ROW_BYTES);
                state_next = ST_ROW_ADDR;
            end

            ST_ROW_ADDR: begin
                base_next  = mul_prod;
                col_next   = x0_reg;
                state_next = ST_BYTE_READ;
            end

            ST_BYTE_READ: begin
                mem_re         = 1'b1;
                mem_addr       = byte_addr(base_reg, col_reg);
                byte_addr_next = mem_addr;
                mask_next      = '0;
                state_next     = ST_PIX_MUL;
            end

            ST_PIX_MUL: begin
                mul_req.a  = OP_W'(dx_abs);
                mul_req.b  = OP_W'(dx_abs);
                state_next = ST_PIX_CMP;
            end

            // Mark the pixel when it lies inside the disc.
            ST_PIX_CMP: begin
                if (dist_sum <= {1'b0, rsq_reg}) begin
                    mask_next = mask_reg | pix_bit;
                end
                col_next = col_inc;
                if (col_inc[2:0] == 3'b000 || col_inc == x1_reg) begin
                    state_next = ST_BYTE_WRITE;
                end else begin
                    state_next = ST_PIX_MUL;
                end
            end

            ST_BYTE_WRITE: begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg & ~mask_reg;
                if (col_reg == x1_reg) begin
                    row_next = row_reg + CRD_W'(1);
                    if (row_reg + CRD_W'(1) == y1_reg) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_ROW_DY;
                    end
                end else begin
                    state_next = ST_BYTE_READ;
                end
            end

            // Hand the result to the output register once it is free.
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_ground_next = ground_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Terrain memory: one port, registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_ground_reg);

    // The pixel under test stays inside the clipped box.
    a_col_in_box: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PIX_MUL || state_reg == ST_PIX_CMP)
        |-> (col_reg >= x0_reg && col_reg < x1_reg))
        else $error("cut column left its bounding box");

    // Every row visited by a cut lies inside the clipped box.
    a_row_in_box: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW_DY) |-> (row_reg < y1_reg))
        else $error("cut row left its bounding box");

    // Memory writes stay inside the terrain store.
    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ({1'b0, mem_addr} < (AW+1)'(DEPTH)))
        else $error("terrain write beyond the store");

    // A finished transaction always shows up on the result channel.
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("result was lost");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import btce_pkg::*;

    localparam int TB_MAX_W     = DEF_MAX_WIDTH;
    localparam int TB_MAX_H     = DEF_MAX_HEIGHT;
    localparam int ROW_BYTES    = TB_MAX_W / 8;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_PCT     = 22;
    localparam int SETTLE_CYCLES = 50;
    localparam int CYCLE_LIMIT  = 3000000;
    // Corner of the level that is fully loaded before any cut or query touches it.
    localparam int CORNER_W     = 32;
    localparam int CORNER_H     = 16;
    // Accepted-count window in which neither side idles.
    localparam int QUIET_FROM   = 1000;
    localparam int QUIET_TO     = 1300;
    // Long result hold-off that backs the block up into its input.
    localparam int HOLD_AT      = 960;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [X_W-1:0]   pos_x;
        logic [Y_W-1:0]   pos_y;
        logic [R_W-1:0]   radius;
        logic             solid;
    } terrain_action_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [ACT_W-1:0]     s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    bitmap_terrain_circle_eraser_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Mirror of the level: size registers, derived extent and the packed mask.
    int unsigned level_w_reg = LW_RESET;
    int unsigned level_h_reg = LH_RESET;
    int          eff_w;
    int          eff_h;
    int          corner_w;
    int          corner_h;
    bit [7:0]    mirror_bytes [ROW_BYTES * TB_MAX_H];
    // Pixels the stimulus has already given a defined value.
    bit [TB_MAX_W-1:0] pix_loaded [TB_MAX_H];

    terrain_action_t queued_actions [$];
    bit              ground_expected [$];

    terrain_action_t offered_action;
    terrain_action_t taken_action;
    logic            taken_flag     = 1'b0;
    int              items_accepted = 0;
    int              rx_hold_left   = 0;
    bit              rx_hold_done   = 1'b0;
    int              cycle_count    = 0;

    int error_count     = 0;
    int results_checked = 0;
    int loads_seen      = 0;
    int cuts_seen       = 0;
    int queries_seen    = 0;
    int unknown_seen    = 0;

    function automatic int level_extent(int unsigned size, int unsigned max_size);
        int unsigned v;
        v = (size > max_size) ? max_size : size;
        return int'(v & ~32'd7);
    endfunction

    function automatic void update_extent();
        eff_w = level_extent(level_w_reg, TB_MAX_W);
        eff_h = level_extent(level_h_reg, TB_MAX_H);
        corner_w = (eff_w < CORNER_W) ? eff_w : CORNER_W;
        corner_h = (eff_h < CORNER_H) ? eff_h : CORNER_H;
        if (corner_w == 0 || corner_h == 0) begin
            corner_w = 0;
            corner_h = 0;
        end
    endfunction

    function automatic int byte_index(int x, int y);
        return y * ROW_BYTES + (x >> 3);
    endfunction

    function automatic logic [7:0] pixel_bit(int x);
        return PIX_MSB >> x[2:0];
    endfunction

    // Applies one action to the mirrored mask and returns the ground bit it answers.
    function automatic bit apply_terrain_action(terrain_action_t act);
        int px, py, rr, x0, y0, x1, y1, dx, dy, i, j;
        bit ground;
        px = act.pos_x;
        py = act.pos_y;
        rr = act.radius;
        ground = 1'b0;
        case (act.action)
            ACT_LOAD: begin
                if (px < eff_w && py < eff_h) begin
                    if (act.solid)
                        mirror_bytes[byte_index(px, py)] |= pixel_bit(px);
                    else
                        mirror_bytes[byte_index(px, py)] &= ~pixel_bit(px);
                end
            end
            ACT_CUT: begin
                // The box is half open: the right and bottom edges are left out.
                x0 = (px - rr < 0) ? 0 : px - rr;
                y0 = (py - rr < 0) ? 0 : py - rr;
                x1 = (px + rr > eff_w) ? eff_w : px + rr;
                y1 = (py + rr > eff_h) ? eff_h : py + rr;
                for (i = y0; i < y1; i++) begin
                    dy = i - py;
                    for (j = x0; j < x1; j++) begin
                        dx = j - px;
                        if (dx * dx + dy * dy <= rr * rr)
                            mirror_bytes[byte_index(j, i)] &= ~pixel_bit(j);
                    end
                end
            end
            ACT_QUERY: begin
                if (px < eff_w && py < eff_h)
                    ground = (mirror_bytes[byte_index(px, py)] & pixel_bit(px)) != 8'd0;
            end
            default: ;
        endcase
        return ground;
    endfunction

    function automatic void add_action(logic [ACT_W-1:0] kind, int unsigned x,
                                       int unsigned y, int unsigned r, bit s);
        terrain_action_t act;
        act.action = kind;
        act.pos_x  = x[X_W-1:0];
        act.pos_y  = y[Y_W-1:0];
        act.radius = r[R_W-1:0];
        act.solid  = s;
        queued_actions.push_back(act);
        if (kind == ACT_LOAD && int'(x) < eff_w && int'(y) < eff_h)
            pix_loaded[y][x] = 1'b1;
    endfunction

    // A cut never reaches past the loaded corner unless the level edge clips it first.
    function automatic void add_random_cut();
        int unsigned r, cx, cy, lim, pick;
        bit full_w, full_h;
        if (corner_w == 0) begin
            add_action(ACT_CUT, $urandom_range(0, 1023), $urandom_range(0, 511),
                       $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
            return;
        end
        full_w = (corner_w == eff_w);
        full_h = (corner_h == eff_h);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            r = 0;
        else if (pick < 75)
            r = $urandom_range(1, 6);
        else if (pick < 92)
            r = $urandom_range(7, 16);
        else
            r = $urandom_range(17, 1023);
        lim = 1023;
        if (!full_w && corner_w < lim) lim = corner_w;
        if (!full_h && corner_h < lim) lim = corner_h;
        if (r > lim) r = lim;
        if (full_w) begin
            cx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, corner_w + r);
            if (cx > 1023) cx = 1023;
        end else begin
            cx = $urandom_range(0, corner_w - r);
        end
        if (full_h) begin
            cy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                             : $urandom_range(0, corner_h + r);
            if (cy > 511) cy = 511;
        end else begin
            cy = $urandom_range(0, corner_h - r);
        end
        add_action(ACT_CUT, cx, cy, r, 1'($urandom_range(0, 1)));
    endfunction

    // Random mix; queries only land on defined pixels or outside the level.
    function automatic void add_random_actions(int count);
        int unsigned pick, x, y;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 511);
            if (pick < 3) begin
                add_action(ACT_UNKNOWN, x, y, $urandom_range(0, 1023),
                           1'($urandom_range(0, 1)));
            end else if (pick < 40) begin
                if (corner_w != 0 && $urandom_range(0, 9) < 7) begin
                    x = $urandom_range(0, corner_w - 1);
                    y = $urandom_range(0, corner_h - 1);
                end
                add_action(ACT_LOAD, x, y, $urandom_range(0, 1023),
                           1'($urandom_range(0, 1)));
            end else if (pick < 75) begin
                if (corner_w != 0 && ($urandom_range(0, 9) < 6 ||
                    (int'(x) < eff_w && int'(y) < eff_h && !pix_loaded[y][x]))) begin
                    x = $urandom_range(0, corner_w - 1);
                    y = $urandom_range(0, corner_h - 1);
                end
                add_action(ACT_QUERY, x, y, $urandom_range(0, 1023),
                           1'($urandom_range(0, 1)));
            end else begin
                add_random_cut();
            end
        end
    endfunction

    // Both size registers go in on back-to-back write cycles.
    task automatic set_level_size(int unsigned w_val, int unsigned h_val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_LEVEL_WIDTH;
        cfg_wdata <= w_val[CFG_W-1:0];
        @(posedge aclk);
        cfg_addr  <= REG_LEVEL_HEIGHT;
        cfg_wdata <= h_val[CFG_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        level_w_reg = w_val & ((1 << LW_W) - 1);
        level_h_reg = h_val & ((1 << LH_W) - 1);
        update_extent();
        @(negedge aclk);
    endtask

    // Holds the sender back until every transaction has produced its result.
    task automatic wait_until_drained();
        do
            @(negedge aclk);
        while (queued_actions.size() != 0 || s_tvalid || taken_flag ||
               ground_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic bit quiet_stretch();
        return items_accepted >= QUIET_FROM && items_accepted < QUIET_TO;
    endfunction

    // Input driver: offers queued actions, with random gaps between transactions.
    always @(posedge aclk) begin : drive_actions
        terrain_action_t nxt;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            taken_flag <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken_action   <= offered_action;
                taken_flag     <= 1'b1;
                items_accepted <= items_accepted + 1;
            end else begin
                taken_flag <= 1'b0;
            end
            if (!s_tvalid || s_tready) begin
                if (queued_actions.size() != 0 &&
                    (quiet_stretch() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = queued_actions.pop_front();
                    offered_action <= nxt;
                    s_tdata  <= {2'b00, nxt.solid, nxt.radius, nxt.pos_y, nxt.pos_x};
                    s_tuser  <= nxt.action;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long stall on the result side once the run is well under way.
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold_left <= 0;
            rx_hold_done <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (!rx_hold_done && items_accepted >= HOLD_AT) begin
            rx_hold_left <= HOLD_CYCLES;
            rx_hold_done <= 1'b1;
        end
    end

    // Result monitor: predicts each accepted action, then checks results in order.
    always @(posedge aclk) begin : check_ground
        bit want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (taken_flag) begin
                ground_expected.push_back(apply_terrain_action(taken_action));
                case (taken_action.action)
                    ACT_LOAD:  loads_seen++;
                    ACT_CUT:   cuts_seen++;
                    ACT_QUERY: queries_seen++;
                    default:   unknown_seen++;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (ground_expected.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("Result with no transaction pending: ground %0b",
                                 m_tdata[0]);
                end else begin
                    want = ground_expected.pop_front();
                    if (m_tdata[0] !== want) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("Mismatch on result %0d (ground): expected %0b, got %0b",
                                     results_checked, want, m_tdata[0]);
                    end
                end
                results_checked++;
            end
            m_tready <= (rx_hold_left == 0) &&
                        (quiet_stretch() || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, ground_expected.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : run_levels
        int x, y;
        update_extent();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset size, 1024 x 512: load the corner that cuts and queries work in.
        for (y = 0; y < CORNER_H; y++)
            for (x = 0; x < CORNER_W; x++)
                add_action(ACT_LOAD, x, y, $urandom_range(0, 1023),
                           1'($urandom_range(0, 1)));
        // Far corner pixel, both values.
        add_action(ACT_LOAD, 1023, 511, 0, 1'b1);
        add_action(ACT_QUERY, 1023, 511, 1023, 1'b0);
        add_action(ACT_LOAD, 1023, 511, 1023, 1'b0);
        add_action(ACT_QUERY, 1023, 511, 0, 1'b1);
        add_action(ACT_LOAD, 1023, 511, 0, 1'b1);
        add_action(ACT_LOAD, 0, 0, 0, 1'b1);
        add_action(ACT_QUERY, 0, 0, 0, 1'b0);
        // Zero radius leaves the mask alone.
        add_action(ACT_CUT, 5, 5, 0, 1'b1);
        add_action(ACT_QUERY, 5, 5, 0, 1'b0);
        // Box clipped at the top-left edge; column 4 sits on the open right edge.
        add_action(ACT_CUT, 0, 0, 4, 1'b0);
        add_action(ACT_QUERY, 3, 0, 0, 1'b0);
        add_action(ACT_QUERY, 4, 0, 0, 1'b0);
        // Circle boundary and open box edges around (20,8).
        add_action(ACT_CUT, 20, 8, 3, 1'b0);
        add_action(ACT_QUERY, 20, 5, 0, 1'b0);
        add_action(ACT_QUERY, 23, 8, 0, 1'b0);
        add_action(ACT_QUERY, 17, 8, 0, 1'b0);
        add_action(ACT_QUERY, 22, 10, 0, 1'b0);
        add_action(ACT_UNKNOWN, 1023, 511, 1023, 1'b1);
        add_random_actions(120);
        wait_until_drained();

        // Sizes that are not multiples of eight round down to 8 x 8.
        set_level_size(13, 15);
        add_action(ACT_QUERY, 8, 0, 0, 1'b0);
        add_action(ACT_LOAD, 9, 3, 0, 1'b1);
        add_action(ACT_QUERY, 9, 3, 0, 1'b0);
        add_action(ACT_QUERY, 1023, 511, 0, 1'b0);
        add_action(ACT_CUT, 4, 4, 1023, 1'b1);
        add_action(ACT_QUERY, 7, 7, 0, 1'b0);
        add_action(ACT_LOAD, 3, 3, 0, 1'b1);
        add_action(ACT_QUERY, 3, 3, 0, 1'b0);
        add_random_actions(80);
        wait_until_drained();

        // Oversized registers saturate at the maximum level.
        set_level_size(2047, 1023);
        add_random_actions(120);
        wait_until_drained();

        // Sizes below eight leave an empty level.
        set_level_size(5, 7);
        add_random_actions(30);
        wait_until_drained();

        set_level_size(24, 512);
        add_random_actions(100);
        wait_until_drained();

        set_level_size(1024, 8);
        add_random_actions(100);
        wait_until_drained();

        set_level_size(40, 20);
        add_random_actions(110);
        wait_until_drained();

        $display("Run covered %0d transactions: %0d loads, %0d cuts, %0d queries, %0d unknown",
                 items_accepted, loads_seen, cuts_seen, queries_seen, unknown_seen);
        $display("over seven level sizes; %0d results checked, %0d failures.",
                 results_checked, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
design/btce_pkg.sv
design/btce_mul.sv
design/bitmap_terrain_circle_eraser_unit.sv
dv/tb_top.sv
